/* sv/rmst_pkg.sv */
// Package for the running mean / standard deviation / threshold block.
// Holds the sequencer state type, field widths, saturation constants, step counts and command codes.
// No dependencies.
`default_nettype none

package rmst_pkg;

	localparam int SAMPLE_W = 32;
	localparam int COUNT_W  = 16;
	localparam int SUM_W    = 48;
	localparam int M2_W     = 64;
	localparam int STD_W    = 31;
	localparam int TOL_W    = 16;
	localparam int TOL_FRAC = 12;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;
	localparam logic [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};
	localparam logic [STD_W-1:0]   STD_MAX   = {STD_W{1'b1}};

	// Divider / square root step counts
	localparam logic [6:0] MEAN_DIV_STEPS = 7'd32;
	localparam logic [6:0] M2_DIV_STEPS   = 7'd64;
	localparam logic [6:0] SQRT_STEPS     = 7'd32;

	// Input command codes
	localparam logic CMD_ACCUM = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPD,
		ST_DIV_MEAN,
		ST_MEAN,
		ST_DLT2,
		ST_MUL,
		ST_M2ADD,
		ST_DIV_M2,
		ST_SQRT,
		ST_SQSAT,
		ST_THRESH,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

/* sv/running_mean_std_threshold_top.sv */
// Sequence: a clear request goes to the threshold and done states and then loads the output. A sample
// request runs update, the mean divide steps, mean, second deviation, multiply, M2 add, the deviation
// divide steps, the square root steps, saturate, threshold and output. The first sample after a
// clear skips the deviation divide and square root.
// One request at a time: a new one is taken only in the idle state. The shared restoring divider
// serves both the mean and the deviation divide. A finished result waits in the output
// register while the next request runs; the sequencer holds in its last state while it waits.
// Reset (arst_n low, asynchronous) clears all statistics, the tolerance and the output valid.
`default_nettype none

module running_mean_std_threshold_top
	import rmst_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	// Configuration write: tolerance, unsigned Q4.12
	input  wire logic         cfg_valid,
	output logic              cfg_ready,
	input  wire logic [15:0]  cfg_data,
	// Input request
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [31:0]  s_tdata,  // [31:0] sample
	input  wire logic         s_tuser,  // [0] command
	// Result
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// [15:0] sample_count, [63:16] total, [95:64] mean, [126:96] std_dev,
	// [158:127] threshold, [159] zero
	output logic [159:0]      m_tdata
);

	state_t state_q, state_d;

	logic [TOL_W-1:0]    tol_q;
	logic [SUM_W-1:0]    sum_q;
	logic [COUNT_W-1:0]  cnt_q;
	logic [SAMPLE_W-1:0] mean_q;
	logic [M2_W-1:0]     m2_q;
	logic [STD_W-1:0]    std_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic                dneg_q;
	logic [31:0]         dmag_q;
	logic [31:0]         d2mag_q;
	logic [63:0]         prod_q;

	// Shared divider / square root registers
	logic [63:0]         dq_q;
	logic [15:0]         rem_q;
	logic [15:0]         den_q;
	logic [6:0]          step_q;
	logic [33:0]         sq_rem_q;
	logic [31:0]         root_q;

	logic                m_tvalid_q;
	logic [159:0]        m_tdata_q;

	logic                accept;
	logic                out_load;
	logic                last_step;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign last_step = (step_q == 7'd1);

	// Running sum with saturation
	logic [SUM_W:0]   sum_ext;
	logic [SUM_W-1:0] sum_sat;
	always_comb begin
		sum_ext = {sum_q[SUM_W-1], sum_q}
			+ {{(SUM_W-SAMPLE_W+1){sample_q[SAMPLE_W-1]}}, sample_q};
		if (!sum_ext[SUM_W] && sum_ext[SUM_W-1]) begin
			sum_sat = SUM_MAX;
		end else if (sum_ext[SUM_W] && !sum_ext[SUM_W-1]) begin
			sum_sat = SUM_MIN;
		end else begin
			sum_sat = sum_ext[SUM_W-1:0];
		end
	end

	// Saturating count and first deviation
	logic [COUNT_W-1:0] cnt_next;
	logic [32:0]        delta;
	logic [32:0]        delta_neg;
	assign cnt_next  = (cnt_q != COUNT_MAX) ? cnt_q + 16'd1 : cnt_q;
	assign delta     = {sample_q[31], sample_q} - {mean_q[31], mean_q};
	assign delta_neg = 33'd0 - delta;

	// Mean update from the quotient, truncated toward zero
	logic [33:0] quot_ext;
	logic [33:0] mean_ext;
	assign quot_ext = {2'b00, dq_q[31:0]};
	assign mean_ext = {{2{mean_q[31]}}, mean_q} + (dneg_q ? 34'd0 - quot_ext : quot_ext);

	// Second deviation from the new mean
	logic [32:0] delta2;
	logic [32:0] delta2_neg;
	assign delta2     = {sample_q[31], sample_q} - {mean_q[31], mean_q};
	assign delta2_neg = 33'd0 - delta2;

	// Saturating M2 accumulate
	logic [M2_W:0]   m2_ext;
	logic [M2_W-1:0] m2_sat;
	assign m2_ext = {1'b0, m2_q} + {1'b0, prod_q};
	assign m2_sat = m2_ext[M2_W] ? {M2_W{1'b1}} : m2_ext[M2_W-1:0];

	// Restoring divide step
	logic [16:0] div_sh;
	logic        div_ge;
	logic [16:0] div_rem;
	assign div_sh  = {rem_q, dq_q[63]};
	assign div_ge  = div_sh >= {1'b0, den_q};
	assign div_rem = div_ge ? div_sh - {1'b0, den_q} : div_sh;

	// Square root step, two radicand bits per step
	logic [35:0] sq_sh;
	logic [35:0] sq_trial;
	logic        sq_ge;
	logic [35:0] sq_rem;
	assign sq_sh    = {sq_rem_q, dq_q[63:62]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign sq_ge    = sq_sh >= sq_trial;
	assign sq_rem   = sq_ge ? sq_sh - sq_trial : sq_sh;

	// Threshold with saturation to 32-bit signed
	logic [34:0] scaled;
	logic [36:0] th_ext;
	logic [31:0] th_sat;
	always_comb begin
		scaled = prod_q[46:TOL_FRAC];
		th_ext = {{5{mean_q[31]}}, mean_q} - {2'b00, scaled};
		if (th_ext[36:31] == {6{th_ext[36]}}) begin
			th_sat = th_ext[31:0];
		end else if (th_ext[36]) begin
			th_sat = 32'h8000_0000;
		end else begin
			th_sat = 32'h7FFF_FFFF;
		end
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and output load
	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (s_tuser == CMD_CLEAR) ? ST_THRESH : ST_UPD;
				end
			end
			ST_UPD:      state_d = ST_DIV_MEAN;
			ST_DIV_MEAN: begin
				if (last_step) begin
					state_d = ST_MEAN;
				end
			end
			ST_MEAN:     state_d = ST_DLT2;
			ST_DLT2:     state_d = ST_MUL;
			ST_MUL:      state_d = ST_M2ADD;
			ST_M2ADD:    state_d = (cnt_q > 16'd1) ? ST_DIV_M2 : ST_THRESH;
			ST_DIV_M2: begin
				if (last_step) begin
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (last_step) begin
					state_d = ST_SQSAT;
				end
			end
			ST_SQSAT:    state_d = ST_THRESH;
			ST_THRESH:   state_d = ST_DONE;
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default:     state_d = ST_IDLE;
		endcase
	end

	// Statistics and tolerance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q  <= '0;
			sum_q  <= '0;
			cnt_q  <= '0;
			mean_q <= '0;
			m2_q   <= '0;
			std_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tol_q <= cfg_data;
			end
			if (accept && s_tuser == CMD_CLEAR) begin
				sum_q  <= '0;
				cnt_q  <= '0;
				mean_q <= '0;
				m2_q   <= '0;
				std_q  <= '0;
			end
			if (state_q == ST_UPD) begin
				sum_q <= sum_sat;
				cnt_q <= cnt_next;
			end
			if (state_q == ST_MEAN) begin
				mean_q <= mean_ext[31:0];
			end
			if (state_q == ST_M2ADD) begin
				m2_q <= m2_sat;
			end
			if (state_q == ST_SQSAT) begin
				std_q <= root_q[31] ? STD_MAX : root_q[30:0];
			end
		end
	end

	// Working datapath: capture, divide, square root, multiply
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= s_tdata;
		end
		unique case (state_q)
			ST_UPD: begin
				dneg_q <= delta[32];
				dmag_q <= delta[32] ? delta_neg[31:0] : delta[31:0];
				dq_q   <= {(delta[32] ? delta_neg[31:0] : delta[31:0]), 32'd0};
				rem_q  <= '0;
				den_q  <= cnt_next;
				step_q <= MEAN_DIV_STEPS;
			end
			ST_DIV_MEAN, ST_DIV_M2: begin
				dq_q   <= {dq_q[62:0], div_ge};
				rem_q  <= div_rem[15:0];
				if (state_q == ST_DIV_M2 && last_step) begin
					sq_rem_q <= '0;
					root_q   <= '0;
					step_q   <= SQRT_STEPS;
				end else begin
					step_q <= step_q - 7'd1;
				end
			end
			ST_DLT2: begin
				d2mag_q <= delta2[32] ? delta2_neg[31:0] : delta2[31:0];
			end
			ST_MUL: begin
				prod_q <= dmag_q * d2mag_q;
			end
			ST_M2ADD: begin
				dq_q   <= m2_sat;
				rem_q  <= '0;
				den_q  <= cnt_q - 16'd1;
				step_q <= M2_DIV_STEPS;
			end
			ST_SQRT: begin
				dq_q     <= {dq_q[61:0], 2'b00};
				sq_rem_q <= sq_rem[33:0];
				root_q   <= {root_q[30:0], sq_ge};
				step_q   <= step_q - 7'd1;
			end
			ST_THRESH: begin
				prod_q <= {17'd0, {31'd0, tol_q} * {16'd0, std_q}};
			end
			default: begin
			end
		endcase
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {1'b0, th_sat, std_q, mean_q, sum_q, cnt_q};
		end
	end

	// A deviation or M2 needs at least two samples
	a_std_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		std_q != '0 |-> cnt_q > 16'd1)
		else $error("std_dev nonzero with fewer than two samples");

	a_m2_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		m2_q != '0 |-> cnt_q > 16'd1)
		else $error("M2 nonzero with fewer than two samples");

	// An accepted request makes the block busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("ready while a request is in progress");

	// A clear request leaves no statistics behind
	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		accept && s_tuser == CMD_CLEAR |=> cnt_q == '0 && sum_q == '0 && mean_q == '0)
		else $error("statistics not cleared");

endmodule

`default_nettype wire
